// File: src/wakeup_timer_slot_scheduler_macros.svh
// Assertion macros shared by the wake-up timer slot scheduler RTL.
// Needs a clk and an active-low arst_n in the scope where a macro is used.
`ifndef WAKEUP_TIMER_SLOT_SCHEDULER_MACROS_SVH
`define WAKEUP_TIMER_SLOT_SCHEDULER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define WTS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define WTS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/wts_pkg.sv
// Types and constants of the wake-up timer slot scheduler.
// No dependencies; imported by wts_eval, the top level and the testbench.
package wts_pkg;

	localparam int THREAD_W  = 8;
	localparam int TICKS_W   = 15;
	localparam int REM_W     = 16;
	localparam int ELAPSED_W = 16;
	localparam int TOL_W     = 8;
	localparam int DIFF_W    = 18;

	// Slot overwritten when an arm finds the table full
	localparam int OVERFLOW_SLOT = 2;

	localparam logic CMD_ARM    = 1'b0;
	localparam logic CMD_EXPIRE = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_WALK = 3'b010,
		ST_FIN  = 3'b100
	} state_t;

	// Outcome of refreshing one active slot
	typedef struct packed {
		logic                    cand;
		logic                    retire;
		logic [TICKS_W-1:0]      value;
		logic signed [REM_W-1:0] new_rem;
	} eval_t;

endpackage

// File: src/wts_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module wts_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: src/wts_eval.sv
// Refresh of one slot: take the elapsed ticks, saturate, classify.
// Depends on wts_pkg.
module wts_eval
	import wts_pkg::*;
(
	input  logic signed [REM_W-1:0] rem,
	input  logic [ELAPSED_W-1:0]    elapsed,
	input  logic [TOL_W-1:0]        tolerance,
	output eval_t                   res
);

	logic signed [DIFF_W-1:0] diff;
	logic [DIFF_W-1:0]        mag;
	logic [DIFF_W-1:0]        tol_ext;
	logic                     neg;
	logic                     pos;

	// Subtract elapsed time and classify the slot
	always_comb begin
		diff    = DIFF_W'(rem) - $signed({2'b00, elapsed});
		neg     = diff[DIFF_W-1];
		pos     = !neg && (diff != '0);
		mag     = neg ? DIFF_W'(-diff) : DIFF_W'(diff);
		tol_ext = DIFF_W'(tolerance);

		res.retire = neg && (mag > tol_ext);
		res.cand   = pos || (neg && (mag < tol_ext));
		res.value  = mag[TICKS_W-1:0];
		// Saturate at the most negative count instead of wrapping
		if (neg && (mag > DIFF_W'(32768))) begin
			res.new_rem = {1'b1, {(REM_W-1){1'b0}}};
		end else begin
			res.new_rem = diff[REM_W-1:0];
		end
	end

endmodule

// File: src/wakeup_timer_slot_scheduler.sv
// Top level of the wake-up timer slot scheduler: control, slot walk, result.
// Depends on wts_pkg, wts_ram, wts_eval and the assertion macro header.
//
// Usage:
// A command word (cmd, thread_num, ticks, elapsed) is taken at a rising edge
// with start high and busy low. cmd arm places the thread in the lowest free
// slot (slot 2 when the table is full, flagged by slot_overflow); cmd expiry
// frees every slot of the thread. Either command then refreshes all slots
// and reports the earliest wake-up on armed, next_thread and next_delay.
// The result is shown for one cycle with done high; the receiver cannot
// stall it, and a new command may be started in that same cycle.
// The block takes no new command before the current one is done. The walk
// reads one slot per cycle from the slot RAM and writes the refreshed count
// back in the following cycle. tolerance is written through tolerance_we and
// tolerance_wdata; the user must write it only while idle; the block does not
// enforce this. Reset clears the active flags, the tolerance and all control
// state; the slot RAM needs no clearing since only active slots are used.
`include "wakeup_timer_slot_scheduler_macros.svh"

module wakeup_timer_slot_scheduler
	import wts_pkg::*;
#(
	parameter int SLOTS = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 tolerance_we,
	input  logic [TOL_W-1:0]     tolerance_wdata,
	input  logic                 start,
	output logic                 busy,
	input  logic                 cmd,
	input  logic [THREAD_W-1:0]  thread_num,
	input  logic [TICKS_W-1:0]   ticks,
	input  logic [ELAPSED_W-1:0] elapsed,
	output logic                 done,
	output logic                 armed,
	output logic [THREAD_W-1:0]  next_thread,
	output logic [TICKS_W-1:0]   next_delay,
	output logic                 slot_overflow
);

	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int ENT_W = THREAD_W + REM_W;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);
	localparam logic [IDX_W-1:0] OVF_IDX  = IDX_W'(OVERFLOW_SLOT);

	state_t                   state_q;
	logic [TOL_W-1:0]         tolerance_q;
	logic [SLOTS-1:0]         active_q;
	logic                     cmd_q;
	logic [THREAD_W-1:0]      tid_q;
	logic [TICKS_W-1:0]       ticks_q;
	logic [ELAPSED_W-1:0]     elapsed_q;
	logic [IDX_W-1:0]         target_q;
	logic                     ovf_q;
	logic                     issue_q;
	logic [IDX_W-1:0]         rd_idx_q;
	logic                     valid_s1;
	logic [IDX_W-1:0]         idx_s1;
	logic                     found_q;
	logic [TICKS_W-1:0]       best_q;
	logic [THREAD_W-1:0]      best_thr_q;

	logic                     accept;
	logic                     rd_en;
	logic [IDX_W-1:0]         free_idx;
	logic                     free_any;
	logic [ENT_W-1:0]         rdata;
	logic [ENT_W-1:0]         wdata;
	logic                     we;
	logic                     fwd;
	logic [THREAD_W-1:0]      eff_thr;
	logic signed [REM_W-1:0]  eff_rem;
	logic                     slot_live;
	logic                     expire_hit;
	logic                     take;
	eval_t                    ev;

	assign accept = start && !busy;
	assign busy   = (state_q != ST_IDLE);
	assign rd_en  = (state_q == ST_WALK) && issue_q;

	// Find the lowest free slot
	always_comb begin
		free_idx = OVF_IDX;
		free_any = 1'b0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!active_q[i]) begin
				free_idx = IDX_W'(i);
				free_any = 1'b1;
			end
		end
	end

	// Slot entry storage: thread id and remaining count
	wts_ram #(
		.WIDTH(ENT_W),
		.DEPTH(SLOTS)
	) u_slot_ram (
		.clk  (clk),
		.we   (we),
		.waddr(idx_s1),
		.wdata(wdata),
		.raddr(rd_idx_q),
		.rdata(rdata)
	);

	// Forward the armed entry in place of the stale RAM word
	always_comb begin
		fwd        = (cmd_q == CMD_ARM) && (idx_s1 == target_q);
		eff_thr    = fwd ? tid_q : rdata[ENT_W-1:REM_W];
		eff_rem    = fwd ? $signed({1'b0, ticks_q}) : $signed(rdata[REM_W-1:0]);
		expire_hit = (cmd_q == CMD_EXPIRE) && (eff_thr == tid_q);
		slot_live  = valid_s1 && active_q[idx_s1] && !expire_hit;
		we         = slot_live;
		wdata      = {eff_thr, ev.new_rem};
		take       = slot_live && ev.cand &&
			(!found_q || (ev.value < best_q) ||
			 ((ev.value == best_q) && (eff_thr < best_thr_q)));
	end

	wts_eval u_eval (
		.rem      (eff_rem),
		.elapsed  (elapsed_q),
		.tolerance(tolerance_q),
		.res      (ev)
	);

	// Hold the tolerance register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tolerance_q <= '0;
		end else if (tolerance_we) begin
			tolerance_q <= tolerance_wdata;
		end
	end

	// Advance the command through idle, slot walk and result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			issue_q  <= 1'b0;
			rd_idx_q <= '0;
			valid_s1 <= 1'b0;
			idx_s1   <= '0;
			done     <= 1'b0;
		end else begin
			valid_s1 <= rd_en;
			idx_s1   <= rd_idx_q;
			done     <= (state_q == ST_FIN);
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q  <= ST_WALK;
						issue_q  <= 1'b1;
						rd_idx_q <= '0;
					end
				end
				ST_WALK: begin
					if (issue_q) begin
						if (rd_idx_q == LAST_IDX) begin
							issue_q <= 1'b0;
						end else begin
							rd_idx_q <= rd_idx_q + 1'b1;
						end
					end
					if (valid_s1 && (idx_s1 == LAST_IDX)) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Set the armed slot on accept, drop expired and retired slots in the walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
		end else if (accept && (cmd == CMD_ARM)) begin
			active_q[free_idx] <= 1'b1;
		end else if (valid_s1 && (expire_hit || ev.retire)) begin
			active_q[idx_s1] <= 1'b0;
		end
	end

	// Latch the command word
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q     <= cmd;
			tid_q     <= thread_num;
			ticks_q   <= ticks;
			elapsed_q <= elapsed;
			target_q  <= free_idx;
			ovf_q     <= (cmd == CMD_ARM) && !free_any;
		end
	end

	// Track the earliest competing slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (accept) begin
			found_q <= 1'b0;
		end else if (take) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			best_q     <= ev.value;
			best_thr_q <= eff_thr;
		end
	end

	// Register the result word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed         <= 1'b0;
			next_thread   <= '0;
			next_delay    <= '0;
			slot_overflow <= 1'b0;
		end else if (state_q == ST_FIN) begin
			armed         <= found_q;
			next_thread   <= found_q ? best_thr_q : '0;
			next_delay    <= found_q ? best_q : '0;
			slot_overflow <= ovf_q;
		end
	end

	`WTS_ASSERT_NEXT(a_accept_busy, accept, busy, "accepted command did not raise busy")
	`WTS_ASSERT_NOW(a_rd_in_walk, valid_s1, state_q == ST_WALK, "slot read outside walk")
	`WTS_ASSERT_NOW(a_idle_clear, done && !armed, (next_thread == '0) && (next_delay == '0), "stopped timer with nonzero result")
	`WTS_ASSERT_NOW(a_delay_nonzero, done && armed, next_delay != '0, "winner with zero delay")

endmodule

// File: tb/sv/wts_wakeup_monitor.sv
`timescale 1ns / 100ps
// Prediction and checking of the wake-up timer slot scheduler's result words.
// Depends on wts_pkg; sits beside the block in the testbench top and only watches.
module wts_wakeup_monitor
	import wts_pkg::*;
#(
	parameter int SLOTS = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 tolerance_we,
	input  logic [TOL_W-1:0]     tolerance_wdata,
	input  logic                 start,
	input  logic                 busy,
	input  logic                 cmd,
	input  logic [THREAD_W-1:0]  thread_num,
	input  logic [TICKS_W-1:0]   ticks,
	input  logic [ELAPSED_W-1:0] elapsed,
	input  logic                 done,
	input  logic                 armed,
	input  logic [THREAD_W-1:0]  next_thread,
	input  logic [TICKS_W-1:0]   next_delay,
	input  logic                 slot_overflow,
	output int                   mismatches,
	output int                   pending
);

	typedef struct packed {
		logic                armed;
		logic [THREAD_W-1:0] thread;
		logic [TICKS_W-1:0]  delay;
		logic                ovf;
	} wakeup_t;

	// Shadow copy of the slot table and the tolerance register
	logic [TOL_W-1:0]    tol_value = '0;
	logic                live [SLOTS];
	logic [THREAD_W-1:0] owner [SLOTS];
	int                  remaining [SLOTS];
	wakeup_t             expected_wakeups [$];

	initial begin
		mismatches = 0;
		pending = 0;
		for (int i = 0; i < SLOTS; i++) begin
			live[i] = 1'b0;
			owner[i] = '0;
			remaining[i] = 0;
		end
	end

	// Apply one command word to the shadow table and pick the earliest wake-up
	task automatic schedule_word(input logic c, input logic [THREAD_W-1:0] tid,
			input logic [TICKS_W-1:0] tk, input logic [ELAPSED_W-1:0] el,
			output wakeup_t res);
		int                  r;
		int                  v;
		int                  best;
		logic [THREAD_W-1:0] best_tid;
		bit                  found;
		bit                  placed;
		bit                  cand;
		found = 0;
		placed = 0;
		best = 0;
		best_tid = '0;
		res = '0;

		// Place an arm in the lowest free slot, else overwrite the overflow slot
		if (c == CMD_ARM) begin
			for (int i = 0; i < SLOTS; i++) begin
				if (!placed && !live[i]) begin
					live[i] = 1'b1;
					owner[i] = tid;
					remaining[i] = int'(tk);
					placed = 1;
				end
			end
			if (!placed) begin
				owner[OVERFLOW_SLOT] = tid;
				remaining[OVERFLOW_SLOT] = int'(tk);
				res.ovf = 1'b1;
			end
		end else begin
			for (int i = 0; i < SLOTS; i++)
				if (live[i] && owner[i] == tid)
					live[i] = 1'b0;
		end

		// Age every live slot, retire late ones, keep the smallest candidate
		for (int i = 0; i < SLOTS; i++) begin
			if (live[i]) begin
				r = remaining[i] - int'(el);
				if (r < -32768)
					r = -32768;
				remaining[i] = r;
				cand = 0;
				v = 0;
				if (r < 0 && r > -int'(tol_value)) begin
					v = -r;
					cand = 1;
				end else if (r < -int'(tol_value)) begin
					live[i] = 1'b0;
				end else if (r > 0) begin
					v = r;
					cand = 1;
				end
				if (cand && (!found || v < best || (v == best && owner[i] < best_tid))) begin
					best = v;
					best_tid = owner[i];
					found = 1;
				end
			end
		end

		res.armed = found;
		res.thread = found ? best_tid : '0;
		res.delay = found ? TICKS_W'(best) : '0;
	endtask

	// Track register writes, compare each result word, predict each accepted word
	always @(posedge clk or negedge arst_n) begin
		wakeup_t seen;
		wakeup_t want;
		wakeup_t pred;
		if (!arst_n) begin
			tol_value = '0;
			for (int i = 0; i < SLOTS; i++)
				live[i] = 1'b0;
			expected_wakeups.delete();
			pending = 0;
		end else begin
			if (tolerance_we)
				tol_value = tolerance_wdata;

			if (done) begin
				seen = '{armed, next_thread, next_delay, slot_overflow};
				if (expected_wakeups.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: unexpected result word armed=%0d thread=%0d delay=%0d ovf=%0d",
							$realtime, seen.armed, seen.thread, seen.delay, seen.ovf);
				end else begin
					want = expected_wakeups.pop_front();
					if (seen !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"%0t: result mismatch: expected armed=%0d thread=%0d ",
								"delay=%0d ovf=%0d, got armed=%0d thread=%0d delay=%0d ovf=%0d"},
								$realtime, want.armed, want.thread, want.delay, want.ovf,
								seen.armed, seen.thread, seen.delay, seen.ovf);
					end
				end
			end

			if (start && !busy) begin
				schedule_word(cmd, thread_num, ticks, elapsed, pred);
				expected_wakeups.push_back(pred);
			end
			pending = expected_wakeups.size();
		end
	end

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps
// Top of the wake-up timer slot scheduler testbench: clock, reset, command stimulus, verdict.
// Depends on wts_pkg, the scheduler RTL and wts_wakeup_monitor.
module testbench;
	import wts_pkg::*;

	localparam int SLOTS       = 8;
	localparam int LATENCY     = SLOTS + 3;
	localparam int IDLE_LIMIT  = 2000;
	localparam int PHASE_ITEMS = 320;
	localparam int PHASES      = 6;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 tolerance_we = 1'b0;
	logic [TOL_W-1:0]     tolerance_wdata = '0;
	logic                 start = 1'b0;
	logic                 cmd = CMD_ARM;
	logic [THREAD_W-1:0]  thread_num = '0;
	logic [TICKS_W-1:0]   ticks = '0;
	logic [ELAPSED_W-1:0] elapsed = '0;
	logic                 busy;
	logic                 done;
	logic                 armed;
	logic [THREAD_W-1:0]  next_thread;
	logic [TICKS_W-1:0]   next_delay;
	logic                 slot_overflow;
	int                   mismatches;
	int                   pending;
	int                   idle_cycles = 0;
	int                   burst_left = 1;
	logic [TOL_W-1:0]     tol_plan [PHASES] = '{8'd0, 8'd255, 8'd1, 8'd40, 8'd0, 8'd128};

	always #10 clk = ~clk;

	wakeup_timer_slot_scheduler #(
		.SLOTS(SLOTS)
	) u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.tolerance_we   (tolerance_we),
		.tolerance_wdata(tolerance_wdata),
		.start          (start),
		.busy           (busy),
		.cmd            (cmd),
		.thread_num     (thread_num),
		.ticks          (ticks),
		.elapsed        (elapsed),
		.done           (done),
		.armed          (armed),
		.next_thread    (next_thread),
		.next_delay     (next_delay),
		.slot_overflow  (slot_overflow)
	);

	wts_wakeup_monitor #(
		.SLOTS(SLOTS)
	) u_monitor (
		.clk            (clk),
		.arst_n         (arst_n),
		.tolerance_we   (tolerance_we),
		.tolerance_wdata(tolerance_wdata),
		.start          (start),
		.busy           (busy),
		.cmd            (cmd),
		.thread_num     (thread_num),
		.ticks          (ticks),
		.elapsed        (elapsed),
		.done           (done),
		.armed          (armed),
		.next_thread    (next_thread),
		.next_delay     (next_delay),
		.slot_overflow  (slot_overflow),
		.mismatches     (mismatches),
		.pending        (pending)
	);

	// Abort when neither a command word nor a result word moves for too long
	always @(posedge clk) begin
		if ((start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Offer one command word, hold it until taken, then maybe end the burst with a gap
	task automatic send_word(input logic c, input logic [THREAD_W-1:0] tid,
			input logic [TICKS_W-1:0] tk, input logic [ELAPSED_W-1:0] el);
		start <= 1'b1;
		cmd <= c;
		thread_num <= tid;
		ticks <= tk;
		elapsed <= el;
		do @(posedge clk); while (busy);
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 12);
			if ($urandom_range(0, 3) != 0) begin
				start <= 1'b0;
				repeat ($urandom_range(1, 25)) @(posedge clk);
			end
		end
	endtask

	// Stop sending, wait for every result word, then write the tolerance
	task automatic set_tolerance_idle(input logic [TOL_W-1:0] value);
		start <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		@(posedge clk);
		tolerance_we <= 1'b1;
		tolerance_wdata <= value;
		@(posedge clk);
		tolerance_we <= 1'b0;
	endtask

	// Random command word: mostly a small thread pool so expiries hit live slots
	task automatic send_random();
		logic                 c;
		logic [THREAD_W-1:0]  tid;
		logic [TICKS_W-1:0]   tk;
		logic [ELAPSED_W-1:0] el;
		int                   pick;
		c = ($urandom_range(0, 99) < 60) ? CMD_ARM : CMD_EXPIRE;
		if ($urandom_range(0, 4) == 0)
			tid = THREAD_W'($urandom);
		else
			tid = THREAD_W'($urandom_range(0, 11) * 23);

		pick = $urandom_range(0, 99);
		if (pick < 45)
			tk = TICKS_W'($urandom_range(0, 400));
		else if (pick < 70)
			tk = TICKS_W'($urandom_range(0, 40));
		else if (pick < 90)
			tk = TICKS_W'($urandom_range(0, 32767));
		else if (pick < 95)
			tk = '1;
		else
			tk = '0;

		pick = $urandom_range(0, 99);
		if (pick < 55)
			el = ELAPSED_W'($urandom_range(0, 40));
		else if (pick < 80)
			el = ELAPSED_W'($urandom_range(0, 300));
		else if (pick < 90)
			el = '0;
		else if (pick < 97)
			el = ELAPSED_W'($urandom_range(0, 65535));
		else
			el = '1;
		send_word(c, tid, tk, el);
	endtask

	initial begin
		int n;
		// Hold reset, then release it
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed words at a small tolerance
		set_tolerance_idle(8'd10);
		send_word(CMD_EXPIRE, 8'd5, 15'd0, 16'd0);       // expiry on an empty table
		send_word(CMD_ARM, 8'd255, 15'h7FFF, 16'd0);
		send_word(CMD_ARM, 8'd3, 15'd100, 16'd0);
		send_word(CMD_ARM, 8'd1, 15'd100, 16'd0);        // equal delay, lower thread wins
		send_word(CMD_ARM, 8'd200, 15'd0, 16'd0);        // zero remaining, no candidate
		send_word(CMD_ARM, 8'd7, 15'd5, 16'd0);
		send_word(CMD_ARM, 8'd8, 15'd50, 16'd0);
		send_word(CMD_ARM, 8'd9, 15'd60, 16'd0);
		send_word(CMD_ARM, 8'd10, 15'd70, 16'd0);        // table now full
		send_word(CMD_ARM, 8'd11, 15'd2, 16'd0);         // full table: overwrite slot 2
		send_word(CMD_ARM, 8'd0, 15'd1, 16'd0);
		send_word(CMD_EXPIRE, 8'd0, 15'h7FFF, 16'd0);    // ticks ignored on expiry
		send_word(CMD_ARM, 8'd12, 15'd40, 16'd10);       // overdue inside tolerance, edge at -tol
		send_word(CMD_EXPIRE, 8'd99, 15'd0, 16'd1);      // unknown thread, refresh still runs
		send_word(CMD_EXPIRE, 8'd3, 15'd0, 16'd0);
		send_word(CMD_ARM, 8'hAA, 15'h5555, 16'hFFFF);   // huge elapsed retires everything
		send_word(CMD_ARM, 8'h55, 15'h2AAA, 16'h0000);
		send_word(CMD_ARM, 8'h55, 15'h2AAA, 16'h2AA0);   // same thread twice
		send_word(CMD_EXPIRE, 8'h55, 15'h0000, 16'h5555);

		// Random phases, each at its own tolerance; fill runs force overflow
		tol_plan[3] = TOL_W'($urandom_range(2, 254));
		for (int p = 0; p < PHASES; p++) begin
			set_tolerance_idle(tol_plan[p]);
			n = 0;
			while (n < PHASE_ITEMS) begin
				if (n % 60 == 0) begin
					for (int k = 0; k < 10; k++)
						send_word(CMD_ARM, THREAD_W'($urandom),
							TICKS_W'($urandom_range(1, 2000)),
							ELAPSED_W'($urandom_range(0, 3)));
					n += 10;
				end else begin
					send_random();
					n++;
				end
			end
		end

		// Drain, then allow for any stray result word
		start <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		repeat (LATENCY + 4) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
